>>> rtl/core/assert_macros.svh
// Assertion macros shared by the square-root RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

>>> rtl/core/fsn_pkg.sv
// Shared types, constants and rounding helpers for the square-root block.
// No dependencies.
package fsn_pkg;

   localparam logic [9:0]  EXP_BIAS     = 10'd127;
   localparam logic [31:0] INV_ROOT_TWO = 32'h3F3504F3;
   localparam logic [31:0] EXP_ONE      = 32'h0080_0000;
   localparam logic [3:0]  MAX_ITER_RST = 4'd8;

   localparam logic [1:0] STATUS_CONVERGED = 2'd0;
   localparam logic [1:0] STATUS_CAP       = 2'd1;
   localparam logic [1:0] STATUS_INVALID   = 2'd2;

   typedef enum logic [1:0] {
      FU_MUL,
      FU_DIV,
      FU_ADD
   } fu_op_type;

   typedef struct packed {
      logic      start;
      fu_op_type op;
   } fu_req_type;

   // Round to nearest even and pack a positive normal result.
   function automatic logic [31:0] round_pack(input logic [9:0] exp_v,
                                              input logic [23:0] mant,
                                              input logic guard,
                                              input logic sticky);
      logic        inc;
      logic [24:0] m;
      logic [9:0]  e;
      inc = guard & (sticky | mant[0]);
      m   = {1'b0, mant} + {24'd0, inc};
      e   = exp_v;
      if (m[24]) begin
         e = exp_v + 10'd1;
         m = m >> 1;
      end
      return {1'b0, e[7:0], m[22:0]};
   endfunction

   // Halve by lowering the exponent field, except at 0 or 255.
   function automatic logic [31:0] halve(input logic [31:0] x);
      if (x[30:23] != 8'd0 && x[30:23] != 8'hFF) begin
         return x - EXP_ONE;
      end
      return x;
   endfunction

endpackage

>>> rtl/core/fsn_fpu.sv
// Shared single-precision unit: multiply, restoring divide, add (positive normals).
// Depends on fsn_pkg.
module fsn_fpu import fsn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  fu_req_type  req,
   input  logic [31:0] opa,
   input  logic [31:0] opb,
   output logic        done,
   output logic [31:0] result
);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_DIV, S_DRND, S_ADD
   } state_type;

   state_type   state_ff, state_in;
   logic [47:0] prod_ff, prod_in;
   logic [9:0]  exp_ff, exp_in;
   logic [25:0] rem_ff, rem_in;
   logic [23:0] dvs_ff, dvs_in;
   logic [24:0] quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [26:0] big_ff, big_in;
   logic [26:0] sml_ff, sml_in;
   logic [31:0] result_ff, result_in;
   logic        done_ff, done_in;

   logic [23:0] ma, mb;
   logic [9:0]  ea, eb;
   logic        swap;
   logic [31:0] bigv, smlv;
   logic [7:0]  dexp;
   logic [26:0] sm27, mask, aligned;
   logic        ge;
   logic [25:0] diff;
   logic [27:0] sum;

   always_comb begin
      ma   = {1'b1, opa[22:0]};
      mb   = {1'b1, opb[22:0]};
      ea   = {2'b0, opa[30:23]};
      eb   = {2'b0, opb[30:23]};
      swap = opb[30:0] > opa[30:0];
      bigv = swap ? opb : opa;
      smlv = swap ? opa : opb;
      dexp = bigv[30:23] - smlv[30:23];
      sm27 = {1'b1, smlv[22:0], 3'b000};
      mask = (27'd1 << dexp) - 27'd1;
      if (dexp >= 8'd27) begin
         aligned = 27'd1;
      end else begin
         aligned = (sm27 >> dexp) | {26'd0, |(sm27 & mask)};
      end
      ge   = rem_ff >= {2'b00, dvs_ff};
      diff = rem_ff - {2'b00, dvs_ff};
      sum  = {1'b0, big_ff} + {1'b0, sml_ff};
   end

   always_comb begin
      state_in  = state_ff;
      prod_in   = prod_ff;
      exp_in    = exp_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      big_in    = big_ff;
      sml_in    = sml_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req.start) begin
               case (req.op)
                  FU_MUL: begin
                     prod_in  = ma * mb;
                     exp_in   = ea + eb - EXP_BIAS;
                     state_in = S_MUL;
                  end
                  FU_DIV: begin
                     dvs_in = mb;
                     quo_in = '0;
                     cnt_in = '0;
                     if (ma < mb) begin
                        rem_in = {1'b0, ma, 1'b0};
                        exp_in = ea - eb + EXP_BIAS - 10'd1;
                     end else begin
                        rem_in = {2'b00, ma};
                        exp_in = ea - eb + EXP_BIAS;
                     end
                     state_in = S_DIV;
                  end
                  FU_ADD: begin
                     big_in   = {1'b1, bigv[22:0], 3'b000};
                     sml_in   = aligned;
                     exp_in   = {2'b0, bigv[30:23]};
                     state_in = S_ADD;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_MUL: begin
            if (prod_ff[47]) begin
               result_in = round_pack(exp_ff + 10'd1, prod_ff[47:24], prod_ff[23],
                                      |prod_ff[22:0]);
            end else begin
               result_in = round_pack(exp_ff, prod_ff[46:23], prod_ff[22],
                                      |prod_ff[21:0]);
            end
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         S_DIV: begin
            // one quotient bit per cycle
            rem_in = ge ? {diff[24:0], 1'b0} : {rem_ff[24:0], 1'b0};
            quo_in = {quo_ff[23:0], ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd24) begin
               state_in = S_DRND;
            end
         end
         S_DRND: begin
            result_in = round_pack(exp_ff, quo_ff[24:1], quo_ff[0], rem_ff != 26'd0);
            done_in   = 1'b1;
            state_in  = S_IDLE;
         end
         S_ADD: begin
            if (sum[27]) begin
               result_in = round_pack(exp_ff + 10'd1, sum[27:4], sum[3], |sum[2:0]);
            end else begin
               result_in = round_pack(exp_ff, sum[26:3], sum[2], |sum[1:0]);
            end
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      prod_ff   <= prod_in;
      exp_ff    <= exp_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      big_ff    <= big_in;
      sml_ff    <= sml_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

>>> rtl/core/float_sqrt_newton.sv
// Newton-Raphson float32 square root: top-level sequencer around fsn_fpu.
// Depends on fsn_pkg, fsn_fpu and assert_macros.svh.
// Sequence: an invalid input goes straight to the result; a valid input runs a divide
//   (issue, quotient bits, round), an add and a compare per refinement step, after a
//   seed multiply for an odd seed, and then presents the result.
// Throughput: one item at a time; req_ready only while idle, shared unit bound.
// Reset: synchronous, active high; cap returns to 8, sequencer to idle.
`include "assert_macros.svh"

module float_sqrt_newton import fsn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_root,
   output logic [3:0]  rsp_iterations,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_max_iterations
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEED, ST_DIV, ST_ADD, ST_CHECK, ST_DONE
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] a_ff, a_in;
   logic [31:0] x0_ff, x0_in;
   logic [31:0] x1_ff, x1_in;
   logic [3:0]  k_ff, k_in;
   logic [31:0] root_ff, root_in;
   logic [1:0]  status_ff, status_in;
   logic [3:0]  max_ff;
   fu_req_type  fu_req_ff, fu_req_in;
   logic [31:0] opa_ff, opa_in;
   logic [31:0] opb_ff, opb_in;

   logic        fu_done;
   logic [31:0] fu_result;
   logic        bad;
   logic        odd;
   logic [31:0] seed;

   fsn_fpu u_fpu (
      .clock  (clock),
      .reset  (reset),
      .req    (fu_req_ff),
      .opa    (opa_ff),
      .opb    (opb_ff),
      .done   (fu_done),
      .result (fu_result)
   );

   // Seed: exponent field becomes (ex>>1)+64 for both parities; an even
   // exponent field means an odd unbiased exponent, which needs 1/sqrt(2).
   always_comb begin
      bad  = req_value[31] || req_value[30:23] == 8'd0 || req_value[30:23] == 8'hFF;
      odd  = ~req_value[23];
      seed = {1'b0, {1'b0, req_value[30:24]} + 8'd64, req_value[22:0]};
   end

   always_comb begin
      state_in  = state_ff;
      a_in      = a_ff;
      x0_in     = x0_ff;
      x1_in     = x1_ff;
      k_in      = k_ff;
      root_in   = root_ff;
      status_in = status_ff;
      opa_in    = opa_ff;
      opb_in    = opb_ff;
      fu_req_in = '{start: 1'b0, op: fu_req_ff.op};
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               a_in = req_value;
               k_in = '0;
               if (bad) begin
                  root_in   = '0;
                  status_in = STATUS_INVALID;
                  state_in  = ST_DONE;
               end else if (odd) begin
                  fu_req_in = '{start: 1'b1, op: FU_MUL};
                  opa_in    = seed;
                  opb_in    = INV_ROOT_TWO;
                  state_in  = ST_SEED;
               end else begin
                  x0_in     = seed;
                  fu_req_in = '{start: 1'b1, op: FU_DIV};
                  opa_in    = req_value;
                  opb_in    = seed;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_SEED: begin
            if (fu_done) begin
               x0_in     = fu_result;
               fu_req_in = '{start: 1'b1, op: FU_DIV};
               opa_in    = a_ff;
               opb_in    = fu_result;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (fu_done) begin
               fu_req_in = '{start: 1'b1, op: FU_ADD};
               opa_in    = x0_ff;
               opb_in    = fu_result;
               state_in  = ST_ADD;
            end
         end
         ST_ADD: begin
            if (fu_done) begin
               x1_in    = halve(fu_result);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // positive normals: equal bits means equal values
            if (x0_ff == x1_ff) begin
               root_in   = x1_ff;
               status_in = STATUS_CONVERGED;
               state_in  = ST_DONE;
            end else if (k_ff >= max_ff) begin
               root_in   = x1_ff;
               status_in = STATUS_CAP;
               state_in  = ST_DONE;
            end else begin
               x0_in     = x1_ff;
               k_in      = k_ff + 4'd1;
               fu_req_in = '{start: 1'b1, op: FU_DIV};
               opa_in    = a_ff;
               opb_in    = x1_ff;
               state_in  = ST_DIV;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fu_req_ff <= '{start: 1'b0, op: FU_MUL};
         max_ff    <= MAX_ITER_RST;
      end else begin
         state_ff  <= state_in;
         fu_req_ff <= fu_req_in;
         if (csr_valid) begin
            max_ff <= csr_max_iterations;
         end
      end
      a_ff      <= a_in;
      x0_ff     <= x0_in;
      x1_ff     <= x1_in;
      k_ff      <= k_in;
      root_ff   <= root_in;
      status_ff <= status_in;
      opa_ff    <= opa_in;
      opb_ff    <= opb_in;
   end

   assign req_ready      = state_ff == ST_IDLE;
   assign rsp_valid      = state_ff == ST_DONE;
   assign rsp_root       = root_ff;
   assign rsp_iterations = k_ff;
   assign rsp_status     = status_ff;
   assign csr_ready      = 1'b1;

   `ASSERT_IMPLY(a_invalid_zero, clock, reset,
      rsp_valid && rsp_status == STATUS_INVALID, rsp_root == 32'd0 && rsp_iterations == 4'd0)
   `ASSERT_IMPLY(a_done_busy, clock, reset, fu_done,
      state_ff == ST_SEED || state_ff == ST_DIV || state_ff == ST_ADD)
   `ASSERT_NEXT(a_start_leaves_idle, clock, reset,
      req_valid && req_ready, !req_ready)

endmodule
